// ===== rtl/dbht_pkg.sv =====
// shared types, constants and codes of the dispatch barrier hazard tracker
package dbht_pkg;

  // store geometry
  localparam int SEG_DEPTH = 16;
  localparam int SEG_AW    = $clog2(SEG_DEPTH);
  localparam int SEG_CW    = $clog2(SEG_DEPTH + 1);

  // pending reads of the open dispatch
  localparam int MAX_READS = 3;
  localparam int PEND_AW   = (MAX_READS > 1) ? $clog2(MAX_READS) : 1;
  localparam int PEND_CW   = $clog2(MAX_READS + 1);

  // field widths
  localparam int ID_BITS   = 16;
  localparam int ADDR_BITS = 40;
  localparam int SIZE_BITS = ADDR_BITS + 1;
  localparam int SUM_BITS  = ADDR_BITS + 2;
  localparam int LO_W      = ADDR_BITS - 2;
  localparam int HI_W      = SUM_BITS - 2;
  localparam int CNT_W     = 32;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  // commands
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NEW   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BARRIER_EVERY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_ORDINAL  = 1'd1;

  // one stored range, in 4-byte word units, end exclusive
  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [LO_W-1:0]    lo;
    logic [HI_W-1:0]    hi;
  } seg_entry_t;

  // access request to one segment store
  typedef struct packed {
    logic              rd_en;
    logic [SEG_AW-1:0] rd_addr;
    logic              wr_en;
    logic [SEG_AW-1:0] wr_addr;
    seg_entry_t        wr_data;
  } stor_req_t;

  // result of one closed dispatch
  typedef struct packed {
    logic             hazard_found;
    logic             barrier_emitted;
    logic             barrier_dropped;
    logic [CNT_W-1:0] dispatch_number;
    logic [CNT_W-1:0] barriers_issued;
  } res_t;

endpackage

// ===== rtl/dispatch_barrier_hazard_tracker_top.sv =====
// top level of the dispatch barrier hazard tracker: config registers, stores, sequencer, output register
//
// One item is handled at a time. A read range scans the write store, and a
// write range scans the write store and then the read store, which hold up
// to 16 ranges each, and then commits up to 3 pending reads: each
// stored range is fetched through the single read port of its store and
// checked by one overlap comparator, and pending reads go into the read store
// one per cycle. A new-graph mark or an unused command needs no scan. A
// finished result waits in the output register while the next item is taken.
// No clearing pass is needed after reset.
module dispatch_barrier_hazard_tracker_top
  import dbht_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [ID_BITS-1:0]    in_buffer_id,
  input  logic [ADDR_BITS-1:0]  in_byte_offset,
  input  logic [SIZE_BITS-1:0]  in_byte_size,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hazard_found,
  output logic                  out_barrier_emitted,
  output logic                  out_barrier_dropped,
  output logic [CNT_W-1:0]      out_dispatch_number,
  output logic [CNT_W-1:0]      out_barriers_issued,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic                  bed_r;
  logic [CFG_DATA_W-1:0] drop_ord_r;
  stor_req_t             wreq, rreq;
  seg_entry_t            query;
  logic                  hit_w, hit_r;
  logic                  res_valid, res_ready;
  res_t                  res;
  logic                  out_valid_r;
  res_t                  out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bed_r      <= 1'b0;
      drop_ord_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BARRIER_EVERY: bed_r      <= cfg_wdata[0];
        CFG_DROP_ORDINAL:  drop_ord_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // write range store
  dbht_store u_wstore (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (wreq),
    .query (query),
    .hit   (hit_w)
  );

  // read range store
  dbht_store u_rstore (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rreq),
    .query (query),
    .hit   (hit_r)
  );

  dbht_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_buffer_id   (in_buffer_id),
    .in_byte_offset (in_byte_offset),
    .in_byte_size   (in_byte_size),
    .barrier_every  (bed_r),
    .drop_ordinal   (drop_ord_r),
    .wreq           (wreq),
    .rreq           (rreq),
    .query          (query),
    .hit_w          (hit_w),
    .hit_r          (hit_r),
    .res_valid      (res_valid),
    .res            (res),
    .res_ready      (res_ready)
  );

  // output register, refilled whenever it is empty or being taken
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hazard_found    = out_r.hazard_found;
  assign out_barrier_emitted = out_r.barrier_emitted;
  assign out_barrier_dropped = out_r.barrier_dropped;
  assign out_dispatch_number = out_r.dispatch_number;
  assign out_barriers_issued = out_r.barriers_issued;

endmodule

// ===== rtl/dbht_store.sv =====
// segment store: one synchronous memory of ranges plus the overlap comparator on its read port
module dbht_store
  import dbht_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  stor_req_t  req,
  input  seg_entry_t query,
  output logic       hit
);

  seg_entry_t mem [SEG_DEPTH];
  seg_entry_t rd_q_r;
  logic       rd_vld_r;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.rd_addr];
    end
  end

  // read data valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= req.rd_en;
    end
  end

  // same buffer and overlapping half-open word ranges
  assign hit = rd_vld_r && (rd_q_r.id == query.id)
               && (HI_W'(rd_q_r.lo) < query.hi)
               && (HI_W'(query.lo) < rd_q_r.hi);

endmodule

// ===== rtl/dbht_ctrl.sv =====
// sequencer: scans the stores, decides barriers, commits ranges and keeps the counters
module dbht_ctrl
  import dbht_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [ID_BITS-1:0]    in_buffer_id,
  input  logic [ADDR_BITS-1:0]  in_byte_offset,
  input  logic [SIZE_BITS-1:0]  in_byte_size,
  input  logic                  barrier_every,
  input  logic [CFG_DATA_W-1:0] drop_ordinal,
  output stor_req_t             wreq,
  output stor_req_t             rreq,
  output seg_entry_t            query,
  input  logic                  hit_w,
  input  logic                  hit_r,
  output logic                  res_valid,
  output res_t                  res,
  input  logic                  res_ready
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCANW  = 3'd1;
  localparam logic [2:0] S_SCANR  = 3'd2;
  localparam logic [2:0] S_RDONE  = 3'd3;
  localparam logic [2:0] S_EVAL   = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic              is_wr_r, is_wr_nxt;
  logic [SEG_CW-1:0] scan_r, scan_nxt;
  logic              acc_r, acc_nxt;
  logic [SEG_CW-1:0] rcnt_r, rcnt_nxt;
  logic [SEG_CW-1:0] wcnt_r, wcnt_nxt;
  logic [PEND_CW-1:0] pcnt_r, pcnt_nxt;
  logic              phaz_r, phaz_nxt;
  logic [PEND_CW-1:0] k_r, k_nxt;
  logic [CNT_W-1:0]  disp_r, disp_nxt;
  logic [CNT_W-1:0]  placed_r, placed_nxt;
  logic [CNT_W-1:0]  issued_r, issued_nxt;
  seg_entry_t        q_r, q_nxt;
  res_t              res_r, res_nxt;

  seg_entry_t        pend_r [MAX_READS];

  logic [SUM_BITS-1:0] end_sum;
  logic              hit_any;
  logic              ovf;
  logic              hz;
  logic              drop;
  logic [SEG_CW-1:0] rbase, wbase;

  // word-aligned end of the incoming range
  assign end_sum = SUM_BITS'(in_byte_offset) + SUM_BITS'(in_byte_size) + SUM_BITS'(3);
  assign hit_any = acc_r | hit_w | hit_r;

  // barrier decision at the close of a dispatch
  assign ovf  = ((SEG_CW + 1)'(rcnt_r) + (SEG_CW + 1)'(pcnt_r) > (SEG_CW + 1)'(SEG_DEPTH))
                || (wcnt_r == SEG_CW'(SEG_DEPTH));
  assign hz   = (barrier_every && (disp_r != '0)) || phaz_r || hit_any || ovf;
  assign drop = (drop_ordinal != '0) && ((placed_r + CNT_W'(1)) == CNT_W'(drop_ordinal))
                && !barrier_every;
  assign rbase = hz ? '0 : rcnt_r;
  assign wbase = hz ? '0 : wcnt_r;

  assign query     = q_r;
  assign res       = res_r;
  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);

  // next-state logic
  always_comb begin
    state_nxt  = state_r;
    is_wr_nxt  = is_wr_r;
    scan_nxt   = scan_r;
    acc_nxt    = hit_any;
    rcnt_nxt   = rcnt_r;
    wcnt_nxt   = wcnt_r;
    pcnt_nxt   = pcnt_r;
    phaz_nxt   = phaz_r;
    k_nxt      = k_r;
    disp_nxt   = disp_r;
    placed_nxt = placed_r;
    issued_nxt = issued_r;
    q_nxt      = q_r;
    res_nxt    = res_r;
    wreq       = '0;
    rreq       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          q_nxt.id = in_buffer_id;
          q_nxt.lo = in_byte_offset[ADDR_BITS-1:2];
          q_nxt.hi = end_sum[SUM_BITS-1:2];
          scan_nxt = '0;
          acc_nxt  = 1'b0;
          case (in_command)
            CMD_READ: begin
              is_wr_nxt = 1'b0;
              if (pcnt_r < PEND_CW'(MAX_READS)) begin
                state_nxt = S_SCANW;
              end
            end
            CMD_WRITE: begin
              is_wr_nxt = 1'b1;
              state_nxt = S_SCANW;
            end
            CMD_NEW: begin
              rcnt_nxt   = '0;
              wcnt_nxt   = '0;
              pcnt_nxt   = '0;
              phaz_nxt   = 1'b0;
              disp_nxt   = '0;
              placed_nxt = '0;
              issued_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCANW: begin
        if (scan_r < wcnt_r) begin
          wreq.rd_en   = 1'b1;
          wreq.rd_addr = scan_r[SEG_AW-1:0];
          scan_nxt     = scan_r + SEG_CW'(1);
        end else if (is_wr_r) begin
          scan_nxt  = '0;
          state_nxt = S_SCANR;
        end else begin
          state_nxt = S_RDONE;
        end
      end
      S_SCANR: begin
        if (scan_r < rcnt_r) begin
          rreq.rd_en   = 1'b1;
          rreq.rd_addr = scan_r[SEG_AW-1:0];
          scan_nxt     = scan_r + SEG_CW'(1);
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_RDONE: begin
        // park the read range; a hit marks the dispatch for a barrier
        phaz_nxt  = phaz_r | hit_any;
        pcnt_nxt  = pcnt_r + PEND_CW'(1);
        state_nxt = S_IDLE;
      end
      S_EVAL: begin
        res_nxt.hazard_found    = hz;
        res_nxt.barrier_emitted = hz && !drop;
        res_nxt.barrier_dropped = hz && drop;
        res_nxt.dispatch_number = disp_r;
        res_nxt.barriers_issued = issued_r;
        if (hz) begin
          placed_nxt = placed_r + CNT_W'(1);
          if (!drop) begin
            issued_nxt = issued_r + CNT_W'(1);
            res_nxt.barriers_issued = issued_r + CNT_W'(1);
          end
        end
        // store the write range behind the surviving entries
        if (wbase < SEG_CW'(SEG_DEPTH)) begin
          wreq.wr_en   = 1'b1;
          wreq.wr_addr = wbase[SEG_AW-1:0];
          wreq.wr_data = q_r;
          wcnt_nxt     = wbase + SEG_CW'(1);
        end else begin
          wcnt_nxt = wbase;
        end
        rcnt_nxt  = rbase;
        k_nxt     = '0;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        // move the pending reads into the read store, one a cycle
        if (k_r < pcnt_r) begin
          if (rcnt_r < SEG_CW'(SEG_DEPTH)) begin
            rreq.wr_en   = 1'b1;
            rreq.wr_addr = rcnt_r[SEG_AW-1:0];
            rreq.wr_data = pend_r[k_r[PEND_AW-1:0]];
            rcnt_nxt     = rcnt_r + SEG_CW'(1);
          end
          k_nxt = k_r + PEND_CW'(1);
        end else begin
          pcnt_nxt  = '0;
          phaz_nxt  = 1'b0;
          disp_nxt  = disp_r + CNT_W'(1);
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      is_wr_r  <= 1'b0;
      scan_r   <= '0;
      acc_r    <= 1'b0;
      rcnt_r   <= '0;
      wcnt_r   <= '0;
      pcnt_r   <= '0;
      phaz_r   <= 1'b0;
      k_r      <= '0;
      disp_r   <= '0;
      placed_r <= '0;
      issued_r <= '0;
    end else begin
      state_r  <= state_nxt;
      is_wr_r  <= is_wr_nxt;
      scan_r   <= scan_nxt;
      acc_r    <= acc_nxt;
      rcnt_r   <= rcnt_nxt;
      wcnt_r   <= wcnt_nxt;
      pcnt_r   <= pcnt_nxt;
      phaz_r   <= phaz_nxt;
      k_r      <= k_nxt;
      disp_r   <= disp_nxt;
      placed_r <= placed_nxt;
      issued_r <= issued_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    res_r <= res_nxt;
    if (state_r == S_RDONE) begin
      pend_r[pcnt_r[PEND_AW-1:0]] <= q_r;
    end
  end

  // scans only read entries that were written since the last barrier
  a_wscan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wreq.rd_en |-> (SEG_CW'(wreq.rd_addr) < wcnt_r))
    else $error("write store scan beyond fill count");

  a_rscan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rreq.rd_en |-> (SEG_CW'(rreq.rd_addr) < rcnt_r))
    else $error("read store scan beyond fill count");

  a_fill_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (rcnt_r <= SEG_CW'(SEG_DEPTH)) && (wcnt_r <= SEG_CW'(SEG_DEPTH))
    && (pcnt_r <= PEND_CW'(MAX_READS)))
    else $error("fill count beyond capacity");

  a_one_result_per_close: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |=> (disp_r == $past(disp_r)) && (state_r == S_COMMIT))
    else $error("dispatch counter moved before commit");

  a_issue_step: assert property (@(posedge clk) disable iff (!rst_n)
    (issued_r != $past(issued_r)) && (issued_r != '0)
    |-> (issued_r == $past(issued_r) + CNT_W'(1)) && $past(state_r == S_EVAL))
    else $error("issued counter moved outside barrier decision");

endmodule

// ===== sim/dispatch_barrier_hazard_tracker_top_tb.sv =====
// self-checking testbench for the dispatch barrier hazard tracker top level
module dispatch_barrier_hazard_tracker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dbht_pkg::*;

  // command code the block leaves unused
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 150;
  // this covers any work in flight
  localparam int DRAIN_CYCLES = 64;
  localparam logic [63:0] WORD_MASK = ~64'd3;

  // one range in byte units, end exclusive
  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [63:0]        lo;
    logic [63:0]        hi;
  } span_t;

  // one row of the directed table; rows with reps > 1 step id by 1 and offset by 16
  typedef struct {
    logic [CMD_W-1:0]     cmd;
    logic [ID_BITS-1:0]   id;
    logic [ADDR_BITS-1:0] off;
    logic [SIZE_BITS-1:0] size;
    int                   reps;
    bit                   pinned;
    res_t                 want;
  } probe_t;

  // register settings and idling of one random phase
  typedef struct {
    bit          every;
    logic [15:0] drop;
    int unsigned send_pct;
    int unsigned recv_pct;
  } setting_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_command = '0;
  logic [ID_BITS-1:0]    in_buffer_id = '0;
  logic [ADDR_BITS-1:0]  in_byte_offset = '0;
  logic [SIZE_BITS-1:0]  in_byte_size = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_hazard_found;
  logic                  out_barrier_emitted;
  logic                  out_barrier_dropped;
  logic [CNT_W-1:0]      out_dispatch_number;
  logic [CNT_W-1:0]      out_barriers_issued;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // tracker state as the testbench sees it
  span_t            rd_store [SEG_DEPTH];
  span_t            wr_store [SEG_DEPTH];
  span_t            open_reads [MAX_READS];
  int unsigned      rd_fill, wr_fill, open_fill;
  bit               open_raw;
  logic [CNT_W-1:0] dispatch_cnt, placed_cnt, issued_cnt;
  bit               every_dispatch;
  logic [15:0]      drop_ordinal;
  res_t             barrier_verdicts [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned failures = 0;
  int unsigned transfers = 0;
  int unsigned results = 0;
  int unsigned placed_seen = 0;
  int unsigned dropped_seen = 0;

  // directed table: extremes, every command and the corner cases
  probe_t probes [14] = '{
    // first dispatch of a graph never needs a barrier
    '{CMD_WRITE, 16'h0000, 40'h0, 41'd16, 1, 1'b1, '{1'b0, 1'b0, 1'b0, 32'd0, 32'd0}},
    // read over the stored write: raw
    '{CMD_READ, 16'h0000, 40'h8, 41'd4, 1, 1'b0, '0},
    '{CMD_READ, 16'hFFFF, 40'hFF_FFFF_FFFF, 41'h100_0000_0000, 1, 1'b0, '0},
    // zero-length read
    '{CMD_READ, 16'h0007, 40'h0, 41'd0, 1, 1'b0, '0},
    // fourth read of one dispatch is ignored
    '{CMD_READ, 16'h0000, 40'h0, 41'd16, 1, 1'b0, '0},
    '{CMD_WRITE, 16'h0003, 40'h100, 41'd4, 1, 1'b1, '{1'b1, 1'b1, 1'b0, 32'd1, 32'd1}},
    // write against the stored empty read
    '{CMD_WRITE, 16'h0007, 40'h0, 41'd1, 1, 1'b0, '0},
    // unaligned empty write widens to one word: war
    '{CMD_WRITE, 16'h0000, 40'hB, 41'd0, 1, 1'b0, '0},
    '{CMD_WRITE, 16'hFFFF, 40'hFF_FFFF_FFFF, 41'h100_0000_0000, 1, 1'b0, '0},
    '{CMD_SPARE, 16'h1234, 40'h40, 41'd8, 1, 1'b0, '0},
    '{CMD_NEW, 16'h0000, 40'h0, 41'd0, 1, 1'b0, '0},
    '{CMD_WRITE, 16'h0100, 40'h0, 41'd4, 1, 1'b1, '{1'b0, 1'b0, 1'b0, 32'd0, 32'd0}},
    // fill the write store with disjoint ranges
    '{CMD_WRITE, 16'h0101, 40'h10, 41'd4, 15, 1'b0, '0},
    // full write store forces a barrier
    '{CMD_WRITE, 16'h0200, 40'h1000, 41'd4, 1, 1'b1, '{1'b1, 1'b1, 1'b0, 32'd16, 32'd1}}
  };

  setting_t settings [PHASES] = '{
    '{1'b0, 16'd0,     0,  0},
    '{1'b0, 16'd1,     56, 0},
    '{1'b1, 16'd0,     0,  56},
    '{1'b0, 16'd3,     14, 14},
    '{1'b1, 16'd65535, 56, 0},
    '{1'b0, 16'd65535, 0,  56},
    '{1'b0, 16'd2,     14, 14},
    '{1'b0, 16'd1,     0,  0}
  };

  dispatch_barrier_hazard_tracker_top dut (.*);

  always #5 clk = ~clk;

  // any stored range of one id that overlaps [a, b)
  function automatic bit store_hit(input bit in_writes, input logic [ID_BITS-1:0] id,
                                   input logic [63:0] a, input logic [63:0] b);
    int unsigned fill;
    span_t s;
    fill = in_writes ? wr_fill : rd_fill;
    for (int k = 0; k < fill; k++) begin
      s = in_writes ? wr_store[k] : rd_store[k];
      if (s.id == id && s.lo < b && a < s.hi) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void restart_graph();
    rd_fill = 0;
    wr_fill = 0;
    open_fill = 0;
    open_raw = 1'b0;
    dispatch_cnt = '0;
    placed_cnt = '0;
    issued_cnt = '0;
  endfunction

  // update tracker state for one range; returns 1 when a dispatch closes
  function automatic bit decide_barrier(input logic [CMD_W-1:0] cmd,
                                        input logic [ID_BITS-1:0] id,
                                        input logic [ADDR_BITS-1:0] off,
                                        input logic [SIZE_BITS-1:0] size,
                                        output res_t verdict);
    logic [63:0] lo, hi;
    bit hazard;
    lo = 64'(off) & WORD_MASK;
    hi = (64'(off) + 64'(size) + 64'd3) & WORD_MASK;
    verdict = '0;
    if (cmd == CMD_NEW) begin
      restart_graph();
      return 1'b0;
    end
    if (cmd == CMD_READ) begin
      if (open_fill < MAX_READS) begin
        if (store_hit(1'b1, id, lo, hi)) open_raw = 1'b1;
        open_reads[open_fill] = '{id: id, lo: lo, hi: hi};
        open_fill++;
      end
      return 1'b0;
    end
    if (cmd != CMD_WRITE) return 1'b0;

    // forced, raw, waw/war, then store overflow
    hazard = (every_dispatch && dispatch_cnt != 0) || open_raw;
    if (!hazard) hazard = store_hit(1'b1, id, lo, hi) || store_hit(1'b0, id, lo, hi);
    if (!hazard) hazard = (rd_fill + open_fill > SEG_DEPTH) || (wr_fill + 1 > SEG_DEPTH);
    if (hazard) begin
      placed_cnt++;
      if (drop_ordinal != 0 && placed_cnt == drop_ordinal && !every_dispatch) begin
        verdict.barrier_dropped = 1'b1;
      end else begin
        verdict.barrier_emitted = 1'b1;
        issued_cnt++;
      end
      rd_fill = 0;
      wr_fill = 0;
    end

    // the closed dispatch joins the segment
    for (int k = 0; k < open_fill; k++) begin
      if (rd_fill < SEG_DEPTH) begin
        rd_store[rd_fill] = open_reads[k];
        rd_fill++;
      end
    end
    if (wr_fill < SEG_DEPTH) begin
      wr_store[wr_fill] = '{id: id, lo: lo, hi: hi};
      wr_fill++;
    end
    open_fill = 0;
    open_raw = 1'b0;
    verdict.hazard_found = hazard;
    verdict.dispatch_number = dispatch_cnt;
    verdict.barriers_issued = issued_cnt;
    dispatch_cnt++;
    return 1'b1;
  endfunction

  // dense ranges collide often, sparse ones reach the field extremes
  function automatic void pick_range(input bit dense, output logic [ID_BITS-1:0] id,
                                     output logic [ADDR_BITS-1:0] off,
                                     output logic [SIZE_BITS-1:0] size);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (dense) begin
      id = ID_BITS'($urandom_range(0, 3));
      off = ADDR_BITS'($urandom_range(0, 255));
      size = (roll < 10) ? '0 : SIZE_BITS'($urandom_range(1, 48));
    end else begin
      id = ID_BITS'($urandom);
      off = ADDR_BITS'({$urandom, $urandom});
      if (roll < 8) size = '0;
      else if (roll < 16) size = SIZE_BITS'(1) << ADDR_BITS;
      else if (roll < 60) size = SIZE_BITS'($urandom_range(0, 64));
      else size = {1'b0, ADDR_BITS'({$urandom, $urandom})};
    end
  endfunction

  // one input transfer, with random gaps ahead of it
  task automatic send_range(input logic [CMD_W-1:0] cmd, input logic [ID_BITS-1:0] id,
                            input logic [ADDR_BITS-1:0] off, input logic [SIZE_BITS-1:0] size,
                            input bit pinned = 1'b0, input res_t pinned_verdict = '0);
    res_t verdict;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_buffer_id <= id;
    in_byte_offset <= off;
    in_byte_size <= size;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (decide_barrier(cmd, id, off, size, verdict)) begin
      if (pinned) verdict = pinned_verdict;
      barrier_verdicts = {barrier_verdicts, verdict};
    end
    if (cmd != CMD_SPARE) transfers++;
    @(negedge clk);
  endtask

  // reads then the closing write; a few are cut short by a new graph
  task automatic random_dispatch();
    logic [ID_BITS-1:0] id;
    logic [ADDR_BITS-1:0] off;
    logic [SIZE_BITS-1:0] size;
    bit dense;
    int unsigned reads;
    dense = $urandom_range(0, 99) < 75;
    reads = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
    repeat (reads) begin
      pick_range(dense, id, off, size);
      send_range(CMD_READ, id, off, size);
    end
    pick_range(dense, id, off, size);
    if (reads > 0 && $urandom_range(0, 99) < 5) send_range(CMD_NEW, id, off, size);
    else send_range(CMD_WRITE, id, off, size);
  endtask

  // long run of sparse dispatches to overflow the read or write store
  task automatic overflow_run();
    logic [ID_BITS-1:0] id;
    logic [ADDR_BITS-1:0] off;
    logic [SIZE_BITS-1:0] size;
    bit read_heavy;
    read_heavy = $urandom_range(0, 1);
    repeat ($urandom_range(17, 20)) begin
      if (read_heavy) begin
        repeat (MAX_READS) begin
          pick_range(1'b0, id, off, size);
          send_range(CMD_READ, id, off, size);
        end
      end
      pick_range(1'b0, id, off, size);
      send_range(CMD_WRITE, id, off, size);
    end
  endtask

  task automatic random_phase(input int unsigned quota);
    logic [ID_BITS-1:0] id;
    logic [ADDR_BITS-1:0] off;
    logic [SIZE_BITS-1:0] size;
    int unsigned stop, roll;
    stop = transfers + quota;
    overflow_run();
    while (transfers < stop) begin
      roll = $urandom_range(0, 99);
      pick_range(1'b0, id, off, size);
      if (roll < 4) send_range(CMD_NEW, id, off, size);
      else if (roll < 6) send_range(CMD_SPARE, id, off, size);
      else if (roll < 12) overflow_run();
      else random_dispatch();
    end
    in_valid <= 1'b0;
  endtask

  // wait out every expected result and any work that gives none
  task automatic drain();
    while (barrier_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // both registers, back to back; upper bits of the one-bit register are junk
  task automatic apply_setting(input setting_t s);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BARRIER_EVERY;
    cfg_wdata <= {(CFG_DATA_W-1)'($urandom), s.every};
    @(negedge clk);
    cfg_index <= CFG_DROP_ORDINAL;
    cfg_wdata <= s.drop;
    @(negedge clk);
    cfg_we <= 1'b0;
    every_dispatch = s.every;
    drop_ordinal = s.drop;
    send_idle_pct = s.send_pct;
    recv_stall_pct = s.recv_pct;
  endtask

  // receiver side
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                      input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (barrier_verdicts.size() == 0) begin
        $error("unexpected result: dispatch_number %0d", out_dispatch_number);
        failures++;
      end else begin
        want = barrier_verdicts.pop_front();
        results++;
        if (out_hazard_found) placed_seen++;
        if (out_barrier_dropped) dropped_seen++;
        check_field("hazard_found", CNT_W'(want.hazard_found), CNT_W'(out_hazard_found));
        check_field("barrier_emitted", CNT_W'(want.barrier_emitted),
                    CNT_W'(out_barrier_emitted));
        check_field("barrier_dropped", CNT_W'(want.barrier_dropped),
                    CNT_W'(out_barrier_dropped));
        check_field("dispatch_number", want.dispatch_number, out_dispatch_number);
        check_field("barriers_issued", want.barriers_issued, out_barriers_issued);
      end
    end
  end

  initial begin : stimulus
    every_dispatch = 1'b0;
    drop_ordinal = '0;
    restart_graph();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table under reset settings
    foreach (probes[i]) begin
      for (int r = 0; r < probes[i].reps; r++) begin
        send_range(probes[i].cmd, probes[i].id + ID_BITS'(r),
                   probes[i].off + ADDR_BITS'(16 * r), probes[i].size,
                   probes[i].pinned, probes[i].want);
      end
    end
    in_valid <= 1'b0;

    // random phases, each under its own settings
    foreach (settings[p]) begin
      drain();
      apply_setting(settings[p]);
      random_phase(ITEMS_PER_PHASE);
    end

    drain();
    $display("%0d input transfers, %0d dispatch results checked", transfers, results);
    $display("%0d barriers placed, %0d dropped, over %0d register settings",
             placed_seen, dropped_seen, PHASES);
    if (failures == 0) $display("PASS dispatch_barrier_hazard_tracker_top");
    else $display("FAIL dispatch_barrier_hazard_tracker_top");
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #10_000_000;
    $display("FAIL dispatch_barrier_hazard_tracker_top");
    $finish;
  end

endmodule

// ===== dispatch_barrier_hazard_tracker_top.f =====
rtl/dbht_pkg.sv
rtl/dbht_store.sv
rtl/dbht_ctrl.sv
rtl/dispatch_barrier_hazard_tracker_top.sv
sim/dispatch_barrier_hazard_tracker_top_tb.sv
